### design/huffman_code_bit_packer_core_assert.svh
// Assertion macros used by the Huffman bit packer top level.
// Plain SystemVerilog concurrent assertions; no other dependencies.
`ifndef HUFFMAN_CODE_BIT_PACKER_CORE_ASSERT_SVH
`define HUFFMAN_CODE_BIT_PACKER_CORE_ASSERT_SVH

// Same-cycle implication, checked at each rising clock edge outside reset.
`define HCBP_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at each rising clock edge outside reset.
`define HCBP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/hcbp_pkg.sv
// Shared constants, function codes and inter-stage structs for the Huffman bit packer.
// No dependencies; imported by every module of the block.
package hcbp_pkg;

  localparam int SYMBOL_COUNT = 256;
  localparam int MAX_CODE_LEN = 32;

  localparam int SYM_W   = 8;
  localparam int CODE_W  = 32;
  localparam int LEN_W   = 6;
  localparam int PEND_W  = 7;
  localparam int PCNT_W  = 3;
  localparam int BYTE_W  = 8;
  localparam int PAD_W   = 3;

  localparam int ADDR_W  = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
  localparam int ACC_W   = PEND_W + MAX_CODE_LEN;
  localparam int TOT_W   = $clog2(ACC_W + 1);
  localparam int MAX_RES = (PEND_W + MAX_CODE_LEN) / BYTE_W;
  localparam int CNT_W   = $clog2(MAX_RES + 1);
  localparam int IDX_W   = (MAX_RES > 1) ? $clog2(MAX_RES) : 1;

  typedef enum logic [1:0] {
    FUNC_WRITE  = 2'd0,
    FUNC_ENCODE = 2'd1,
    FUNC_FLUSH  = 2'd2
  } func_e;

  // Looked-up item as seen by the packing stage.
  typedef struct packed {
    logic              vld;
    logic [1:0]        func;
    logic [LEN_W-1:0]  len;
    logic [CODE_W-1:0] code;
  } lookup_t;

  // Load request from the packing stage into the output serializer.
  typedef struct packed {
    logic                          load;
    logic [CNT_W-1:0]              cnt;
    logic [MAX_RES-1:0][BYTE_W-1:0] bytes;
    logic                          bvalid;
    logic [PAD_W-1:0]              pad;
  } emit_load_t;

endpackage

### design/huffman_code_bit_packer_core.sv
// Top level of the Huffman encoder back end: code table, bit packer, byte output.
// Depends on hcbp_pkg, hcbp_lookup, hcbp_merge, hcbp_emit and the assertion header.
//
// The block takes one word per cycle on the input channel (func_i, symbol_i,
// code_word_i, code_length_i) while in_stall_o is low. A table write stores
// a symbol's code and its length (lengths above MAX_CODE_LEN saturate) at the
// accept edge, so an encode of that symbol may follow in the very next cycle.
// An encode looks the symbol up in the code table with a registered read, then
// appends the code to the pending bits in the packing stage and hands every
// completed byte, earliest bit in the MSB, to the output register. A flush
// pads the pending bits with zeros and emits one word with the number of pad
// bits; a flush with nothing pending emits a word with byte_valid_o low.
// last_o marks the final word of each item. Output rate: one word per cycle
// while out_stall_i is low, from the output register behind the lookup stage
// register. An item that completes n bytes (at most four with 32-bit codes)
// holds the serializer until they are taken; items that produce no output
// (table writes, encodes that complete no byte, unused codes) keep passing
// through meanwhile, while the next byte-producing item waits in the lookup
// stage and stalls the input. Table lengths reset to zero via per-entry valid
// flops (no clearing pass); code words hold whatever they held until written.
`include "huffman_code_bit_packer_core_assert.svh"

module huffman_code_bit_packer_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  func_i,
  input  logic [hcbp_pkg::SYM_W-1:0]  symbol_i,
  input  logic [hcbp_pkg::CODE_W-1:0] code_word_i,
  input  logic [hcbp_pkg::LEN_W-1:0]  code_length_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [hcbp_pkg::BYTE_W-1:0] out_byte_o,
  output logic                        byte_valid_o,
  output logic [hcbp_pkg::PAD_W-1:0]  pad_bits_o,
  output logic                        last_o
);
  import hcbp_pkg::*;

  lookup_t    lk;
  emit_load_t emit_ld;
  logic       adv;
  logic       emit_free;
  logic       in_accept;

  // Stall only while the lookup stage holds an item that cannot move on.
  assign in_stall_o = lk.vld && !adv;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Table memories and lookup stage register.
  hcbp_lookup u_lookup (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (in_accept),
    .func_i        (func_i),
    .symbol_i      (symbol_i),
    .code_word_i   (code_word_i),
    .code_length_i (code_length_i),
    .adv_i         (adv),
    .lk_o          (lk)
  );

  // Pending-bit merge, byte split and flush padding.
  hcbp_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .lk_i        (lk),
    .emit_free_i (emit_free),
    .adv_o       (adv),
    .ld_o        (emit_ld)
  );

  // Output register: drain one byte per accepted output word.
  hcbp_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ld_i         (emit_ld),
    .out_stall_i  (out_stall_i),
    .emit_free_o  (emit_free),
    .out_valid_o  (out_valid_o),
    .out_byte_o   (out_byte_o),
    .byte_valid_o (byte_valid_o),
    .pad_bits_o   (pad_bits_o),
    .last_o       (last_o)
  );

  // A load into the serializer never overwrites bytes still owed downstream.
  `HCBP_ASSERT_SAME(a_load_when_free, clk_i, rst_ni, emit_ld.load, emit_free, "serializer overrun")

  // An empty flush carries nothing but the last marker.
  `HCBP_ASSERT_SAME(a_empty_flush, clk_i, rst_ni, out_valid_o && !byte_valid_o,
    last_o && (pad_bits_o == '0) && (out_byte_o == '0), "bad empty flush word")

  // Padding appears only on a flush word, which is always the last one.
  `HCBP_ASSERT_SAME(a_pad_last, clk_i, rst_ni, out_valid_o && (pad_bits_o != '0),
    last_o && byte_valid_o, "padding on a non-final word")

  // Taking a non-final word leaves more bytes of the same item to emit.
  `HCBP_ASSERT_NEXT(a_more_follow, clk_i, rst_ni, out_valid_o && !out_stall_i && !last_o,
    out_valid_o, "item bytes lost")

endmodule

### design/hcbp_lookup.sv
// Code table and lookup stage of the Huffman bit packer.
// Depends on hcbp_pkg; holds the code and length memories and the stage register.
module hcbp_lookup (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      accept_i,
  input  logic [1:0]                func_i,
  input  logic [hcbp_pkg::SYM_W-1:0]  symbol_i,
  input  logic [hcbp_pkg::CODE_W-1:0] code_word_i,
  input  logic [hcbp_pkg::LEN_W-1:0]  code_length_i,
  input  logic                      adv_i,
  output hcbp_pkg::lookup_t         lk_o
);
  import hcbp_pkg::*;

  localparam logic [SYM_W:0] SymLimit = (SYM_W + 1)'(SYMBOL_COUNT);
  localparam logic [LEN_W-1:0] LenMax = LEN_W'(MAX_CODE_LEN);

  logic [CODE_W-1:0] code_mem [SYMBOL_COUNT];
  logic [LEN_W-1:0]  len_mem  [SYMBOL_COUNT];
  logic [SYMBOL_COUNT-1:0] ent_vld_q;

  logic [CODE_W-1:0] rd_code_q;
  logic [LEN_W-1:0]  rd_len_q;
  logic              a_vld_q;
  logic [1:0]        a_func_q;
  logic              a_hit_q;

  logic              sym_ok;
  logic [ADDR_W-1:0] addr;
  logic              wr_en;
  logic [LEN_W-1:0]  len_sat;

  assign sym_ok  = ({1'b0, symbol_i} < SymLimit);
  assign addr    = symbol_i[ADDR_W-1:0];
  assign wr_en   = accept_i && (func_i == FUNC_WRITE) && sym_ok;
  assign len_sat = (code_length_i > LenMax) ? LenMax : code_length_i;

  // Table write and registered read both happen at the accept edge.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      code_mem[addr] <= code_word_i;
      len_mem[addr]  <= len_sat;
    end
    if (accept_i) begin
      rd_code_q <= code_mem[addr];
      rd_len_q  <= len_mem[addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_vld_q <= '0;
      a_vld_q   <= 1'b0;
      a_func_q  <= FUNC_WRITE;
      a_hit_q   <= 1'b0;
    end else begin
      if (wr_en) begin
        ent_vld_q[addr] <= 1'b1;
      end
      if (accept_i) begin
        a_vld_q  <= 1'b1;
        a_func_q <= func_i;
        a_hit_q  <= sym_ok && ent_vld_q[addr];
      end else if (adv_i) begin
        a_vld_q <= 1'b0;
      end
    end
  end

  // A never-written or out-of-range symbol reads as length zero.
  always_comb begin
    lk_o.vld  = a_vld_q;
    lk_o.func = a_func_q;
    lk_o.len  = a_hit_q ? rd_len_q : '0;
    lk_o.code = rd_code_q;
  end

endmodule

### design/hcbp_merge.sv
// Bit packing stage: merges a looked-up code with the pending bits.
// Depends on hcbp_pkg; owns the pending-bit register and pending count.
module hcbp_merge (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  hcbp_pkg::lookup_t    lk_i,
  input  logic                 emit_free_i,
  output logic                 adv_o,
  output hcbp_pkg::emit_load_t ld_o
);
  import hcbp_pkg::*;

  logic [PEND_W-1:0] pend_q, pend_d;
  logic [PCNT_W-1:0] pend_cnt_q, pend_cnt_d;

  logic [ACC_W-1:0]  code_ext;
  logic [ACC_W-1:0]  acc;
  logic [ACC_W-1:0]  shifted;
  logic [TOT_W-1:0]  total;
  logic [CNT_W-1:0]  nbytes;
  logic [PCNT_W-1:0] leftover;
  logic [PEND_W-1:0] new_pend;
  logic [PAD_W-1:0]  fpad;
  logic [BYTE_W-1:0] fbyte;
  logic              need;

  always_comb begin
    code_ext = ACC_W'(lk_i.code) & ((ACC_W'(1) << lk_i.len) - ACC_W'(1));
    acc      = (ACC_W'(pend_q) << lk_i.len) | code_ext;
    total    = TOT_W'(pend_cnt_q) + TOT_W'(lk_i.len);
    nbytes   = CNT_W'(total >> 3);
    leftover = total[PCNT_W-1:0];
    shifted  = acc >> leftover;
    new_pend = PEND_W'(acc & ((ACC_W'(1) << leftover) - ACC_W'(1)));
    fpad     = PAD_W'(4'd8 - {1'b0, pend_cnt_q});
    fbyte    = BYTE_W'({1'b0, pend_q} << fpad);
  end

  always_comb begin
    case (lk_i.func)
      FUNC_ENCODE: need = (nbytes != '0);
      FUNC_FLUSH:  need = 1'b1;
      default:     need = 1'b0;
    endcase
  end

  assign adv_o = lk_i.vld && (!need || emit_free_i);

  always_comb begin
    ld_o.load   = adv_o && need;
    ld_o.cnt    = nbytes;
    ld_o.bvalid = 1'b1;
    ld_o.pad    = '0;
    for (int k = 0; k < MAX_RES; k++) begin
      ld_o.bytes[k] = shifted[k*BYTE_W +: BYTE_W];
    end
    if (lk_i.func == FUNC_FLUSH) begin
      ld_o.cnt      = CNT_W'(1);
      ld_o.bytes    = '0;
      ld_o.bytes[0] = (pend_cnt_q != '0) ? fbyte : '0;
      ld_o.bvalid   = (pend_cnt_q != '0);
      ld_o.pad      = (pend_cnt_q != '0) ? fpad : '0;
    end
  end

  always_comb begin
    pend_d     = pend_q;
    pend_cnt_d = pend_cnt_q;
    if (adv_o) begin
      case (lk_i.func)
        FUNC_ENCODE: begin
          pend_d     = new_pend;
          pend_cnt_d = leftover;
        end
        FUNC_FLUSH: begin
          pend_d     = '0;
          pend_cnt_d = '0;
        end
        default: begin
          pend_d     = pend_q;
          pend_cnt_d = pend_cnt_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q     <= '0;
      pend_cnt_q <= '0;
    end else begin
      pend_q     <= pend_d;
      pend_cnt_q <= pend_cnt_d;
    end
  end

endmodule

### design/hcbp_emit.sv
// Output register and byte serializer of the Huffman bit packer.
// Depends on hcbp_pkg; emits the bytes of one item, earliest first.
module hcbp_emit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  hcbp_pkg::emit_load_t      ld_i,
  input  logic                      out_stall_i,
  output logic                      emit_free_o,
  output logic                      out_valid_o,
  output logic [hcbp_pkg::BYTE_W-1:0] out_byte_o,
  output logic                      byte_valid_o,
  output logic [hcbp_pkg::PAD_W-1:0]  pad_bits_o,
  output logic                      last_o
);
  import hcbp_pkg::*;

  logic [CNT_W-1:0]  e_cnt_q, e_cnt_d;
  logic [BYTE_W-1:0] e_byte_q [MAX_RES];
  logic              e_bv_q;
  logic [PAD_W-1:0]  e_pad_q;
  logic [CNT_W-1:0]  cnt_m1;
  logic              out_take;

  assign cnt_m1      = e_cnt_q - CNT_W'(1);
  assign out_take    = (e_cnt_q != '0) && !out_stall_i;
  assign emit_free_o = (e_cnt_q == '0) || ((e_cnt_q == CNT_W'(1)) && !out_stall_i);

  assign out_valid_o  = (e_cnt_q != '0);
  assign out_byte_o   = e_byte_q[cnt_m1[IDX_W-1:0]];
  assign byte_valid_o = e_bv_q;
  assign pad_bits_o   = e_pad_q;
  assign last_o       = (e_cnt_q == CNT_W'(1));

  always_comb begin
    e_cnt_d = e_cnt_q;
    if (ld_i.load) begin
      e_cnt_d = ld_i.cnt;
    end else if (out_take) begin
      e_cnt_d = cnt_m1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_cnt_q <= '0;
    end else begin
      e_cnt_q <= e_cnt_d;
    end
  end

  // Payload: load only, hold otherwise.
  always_ff @(posedge clk_i) begin
    if (ld_i.load) begin
      for (int k = 0; k < MAX_RES; k++) begin
        e_byte_q[k] <= ld_i.bytes[k];
      end
      e_bv_q  <= ld_i.bvalid;
      e_pad_q <= ld_i.pad;
    end
  end

endmodule
